@@ rtl/afr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afr_pkg
// Shared constants for the audio fragment reassembler: sizes, register
// indexes and item kind codes.
// ----------------------------------------------------------------------------
package afr_pkg;

   // default sizes
   localparam int AFR_BUFFER_BYTES  = 1024;
   localparam int AFR_MAX_FRAGMENTS = 16;

   // frame id held while no frame is open
   localparam logic [15:0] NO_FRAME = 16'hFFFF;

   // register port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_RX_ENABLE        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_MAGIC   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VERSION = 2'd2;

   // input item kinds
   localparam logic KIND_FRAGMENT = 1'b0;
   localparam logic KIND_READ     = 1'b1;

   // result item kinds
   localparam logic RESULT_DONE = 1'b0;
   localparam logic RESULT_READ = 1'b1;

endpackage
`default_nettype wire

@@ rtl/afr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afr_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module afr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/audio_fragment_reassembler.sv @@
// A result passes the pending register, then the result register, to rsp.
// Throughput: one item per cycle while req_stall is low. The frame buffer is
// split into even and odd byte banks; a sample read needs one port on each.
// Items stall only while a finished result waits in both result registers.
// Reset: synchronous; closes the open frame and restores the registers.
// The frame buffer is not cleared; no clearing pass is made.
`default_nettype none
// ----------------------------------------------------------------------------
// audio_fragment_reassembler
// Writes fragment payload bytes into a frame buffer, tracks fragment arrival
// in a bitmap and reports frame completion; also serves sample reads.
// ----------------------------------------------------------------------------
module audio_fragment_reassembler
   import afr_pkg::*;
#(
   parameter int BUFFER_BYTES  = AFR_BUFFER_BYTES,
   parameter int MAX_FRAGMENTS = AFR_MAX_FRAGMENTS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   // input items
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_kind,
   input  wire logic [15:0]            req_magic,
   input  wire logic [7:0]             req_version,
   input  wire logic [15:0]            req_frame_id,
   input  wire logic [7:0]             req_frag_index,
   input  wire logic [7:0]             req_frag_total,
   input  wire logic [15:0]            req_byte_offset,
   input  wire logic [15:0]            req_frame_length,
   input  wire logic [7:0]             req_payload_length,
   input  wire logic [7:0]             req_byte_position,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic [8:0]             req_read_index,
   // result items
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_result_kind,
   output logic      [15:0]            rsp_done_frame_id,
   output logic      [10:0]            rsp_done_length,
   output logic                        rsp_playable,
   output logic signed [15:0]          rsp_sample_value
);

   localparam int TW         = $clog2(BUFFER_BYTES + 1);
   localparam int FW         = $clog2(MAX_FRAGMENTS + 1);
   localparam int BANK_DEPTH = (BUFFER_BYTES + 1) / 2;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int READ_LIMIT = BUFFER_BYTES / 2;

   typedef struct packed {
      logic        kind;
      logic [15:0] frame_id;
      logic [10:0] length;
      logic        playable;
      logic        rd_ok;
   } pend_type;

   // configuration registers
   logic        rx_enable_ff;
   logic [15:0] exp_magic_ff;
   logic [7:0]  exp_version_ff;

   // frame state
   logic [15:0]              cur_frame_ff, cur_frame_in;
   logic [MAX_FRAGMENTS-1:0] arrival_ff, arrival_in;
   logic [FW-1:0]            frag_total_ff, frag_total_in;
   logic [TW-1:0]            byte_total_ff, byte_total_in;

   // result path
   logic     pend_valid_ff, pend_valid_in;
   pend_type pend_ff, pend_in;
   logic     rsp_valid_ff;
   logic     rsp_kind_ff;
   logic [15:0] rsp_frame_id_ff;
   logic [10:0] rsp_length_ff;
   logic        rsp_playable_ff;
   logic [15:0] rsp_sample_ff;

   logic accept;
   logic out_adv;
   logic frame_open;
   logic hdr_ok;
   logic new_frame;
   logic mismatch;
   logic frag_take;
   logic last_byte;
   logic complete;
   logic [16:0] end_sum;
   logic [16:0] byte_addr;
   logic [16:0] read_ext;
   logic        read_ok;
   logic [7:0]  total_sel;
   logic [MAX_FRAGMENTS-1:0] bits_base;
   logic [MAX_FRAGMENTS-1:0] bits_new;
   logic [MAX_FRAGMENTS-1:0] need;
   logic        wr_ok;
   logic [7:0]  even_rd;
   logic [7:0]  odd_rd;

   // handshakes
   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_valid_ff && !out_adv;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_enable_ff   <= 1'b1;
         exp_magic_ff   <= '0;
         exp_version_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RX_ENABLE:        rx_enable_ff   <= csr_data[0];
            CSR_EXPECTED_MAGIC:   exp_magic_ff   <= csr_data;
            CSR_EXPECTED_VERSION: exp_version_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // fragment header checks
   assign frame_open = byte_total_ff != '0;
   assign end_sum    = {1'b0, req_byte_offset} + {9'b0, req_payload_length};
   assign byte_addr  = {1'b0, req_byte_offset} + {9'b0, req_byte_position};

   always_comb begin
      hdr_ok = rx_enable_ff
            && req_magic == exp_magic_ff
            && req_version == exp_version_ff
            && req_frame_length != 16'd0
            && {1'b0, req_frame_length} <= 17'(BUFFER_BYTES)
            && req_frag_total != 8'd0
            && req_frag_total <= 8'(MAX_FRAGMENTS)
            && req_frag_index < req_frag_total
            && req_payload_length != 8'd0
            && end_sum <= {1'b0, req_frame_length}
            && req_byte_position < req_payload_length;
   end

   assign new_frame = !frame_open || req_frame_id != cur_frame_ff;
   assign mismatch  = !new_frame
                   && (req_frame_length != {{(16-TW){1'b0}}, byte_total_ff}
                   ||  req_frag_total != {{(8-FW){1'b0}}, frag_total_ff});
   assign frag_take = accept && req_kind == KIND_FRAGMENT && hdr_ok && !mismatch;
   assign last_byte = (req_byte_position + 8'd1) == req_payload_length;
   assign wr_ok     = frag_take && byte_addr < 17'(BUFFER_BYTES);

   // arrival bitmap and completion test
   assign total_sel = new_frame ? req_frag_total : {{(8-FW){1'b0}}, frag_total_ff};
   assign bits_base = new_frame ? '0 : arrival_ff;

   always_comb begin
      bits_new = bits_base;
      if (last_byte) begin
         bits_new = bits_base | (MAX_FRAGMENTS'(1) << req_frag_index);
      end
      for (int i = 0; i < MAX_FRAGMENTS; i++) begin
         need[i] = 8'(i) < total_sel;
      end
   end

   assign complete = frag_take && last_byte && ((bits_new & need) == need);

   // frame state update
   always_comb begin
      cur_frame_in  = cur_frame_ff;
      arrival_in    = arrival_ff;
      frag_total_in = frag_total_ff;
      byte_total_in = byte_total_ff;
      if (complete) begin
         cur_frame_in  = NO_FRAME;
         arrival_in    = '0;
         frag_total_in = '0;
         byte_total_in = '0;
      end else if (frag_take) begin
         cur_frame_in  = req_frame_id;
         arrival_in    = bits_new;
         frag_total_in = req_frag_total[FW-1:0];
         byte_total_in = req_frame_length[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_frame_ff  <= NO_FRAME;
         arrival_ff    <= '0;
         frag_total_ff <= '0;
         byte_total_ff <= '0;
      end else begin
         cur_frame_ff  <= cur_frame_in;
         arrival_ff    <= arrival_in;
         frag_total_ff <= frag_total_in;
         byte_total_ff <= byte_total_in;
      end
   end

   // frame buffer, split in even and odd byte banks
   assign read_ext = {8'b0, req_read_index};
   assign read_ok  = read_ext < 17'(READ_LIMIT);

   afr_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (wr_ok && !byte_addr[0]),
      .wr_addr (byte_addr[BANK_AW:1]),
      .wr_data (req_data_byte),
      .rd_en   (accept && req_kind == KIND_READ),
      .rd_addr (read_ext[BANK_AW-1:0]),
      .rd_data (even_rd)
   );

   afr_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (wr_ok && byte_addr[0]),
      .wr_addr (byte_addr[BANK_AW:1]),
      .wr_data (req_data_byte),
      .rd_en   (accept && req_kind == KIND_READ),
      .rd_addr (read_ext[BANK_AW-1:0]),
      .rd_data (odd_rd)
   );

   // pending result, aligned with the buffer read data
   always_comb begin
      pend_in          = pend_ff;
      pend_valid_in    = pend_valid_ff && !out_adv;
      if (accept && (req_kind == KIND_READ || complete)) begin
         pend_valid_in    = 1'b1;
         pend_in.kind     = req_kind;
         pend_in.frame_id = (req_kind == KIND_READ) ? 16'd0 : req_frame_id;
         pend_in.length   = (req_kind == KIND_READ) ? 11'd0 : req_frame_length[10:0];
         pend_in.playable = req_kind == KIND_FRAGMENT
                         && req_frame_length >= 16'd2 && !req_frame_length[0];
         pend_in.rd_ok    = req_kind == KIND_READ && read_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && pend_valid_ff) begin
         rsp_kind_ff     <= pend_ff.kind;
         rsp_frame_id_ff <= pend_ff.frame_id;
         rsp_length_ff   <= pend_ff.length;
         rsp_playable_ff <= pend_ff.playable;
         rsp_sample_ff   <= pend_ff.rd_ok ? {odd_rd, even_rd} : 16'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_done_frame_id = rsp_frame_id_ff;
   assign rsp_done_length   = rsp_length_ff;
   assign rsp_playable      = rsp_playable_ff;
   assign rsp_sample_value  = rsp_sample_ff;

`ifndef ASSERT_OFF
   // a completed frame leaves the block closed
   a_close_on_done: assert property (@(posedge clock) disable iff (reset)
      complete |=> (byte_total_ff == '0 && arrival_ff == '0 && cur_frame_ff == NO_FRAME))
      else $error("frame not closed after completion");

   // a pending result is held until the result register takes it
   a_pend_held: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !out_adv) |=> (pend_valid_ff && $stable(pend_ff)))
      else $error("pending result lost");

   // items stall only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (pend_valid_ff && rsp_valid_ff))
      else $error("input stalled without a waiting result");

   // no arrival bits while no frame is open
   a_bits_closed: assert property (@(posedge clock) disable iff (reset)
      !frame_open |-> arrival_ff == '0)
      else $error("arrival bits set with no open frame");
`endif

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the audio fragment reassembler. A table of directed
// items covers drops, frame switches and buffer extremes, then random frames,
// reads and noise run under several register settings. Every result item is
// compared with a typed row or a local model of reassembly and frame buffer.
// ----------------------------------------------------------------------------
module tb_top;
   import afr_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [15:0] magic;
      logic [7:0]  version;
      logic [15:0] frame_id;
      logic [7:0]  frag_index;
      logic [7:0]  frag_total;
      logic [15:0] byte_offset;
      logic [15:0] frame_length;
      logic [7:0]  payload_length;
      logic [7:0]  byte_position;
      logic [7:0]  data_byte;
      logic [8:0]  read_index;
   } frag_item_type;

   typedef struct packed {
      logic               result_kind;
      logic [15:0]        done_frame_id;
      logic [10:0]        done_length;
      logic               playable;
      logic signed [15:0] sample_value;
   } rsp_item_type;

   // where a directed row takes its expectation from
   typedef enum logic [1:0] {EXP_PREDICTED, EXP_DROPPED, EXP_TYPED} exp_src_type;

   typedef struct packed {
      frag_item_type item;
      exp_src_type   src;
      rsp_item_type  want;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_kind = 1'b0;
   logic [15:0]            req_magic = '0;
   logic [7:0]             req_version = '0;
   logic [15:0]            req_frame_id = '0;
   logic [7:0]             req_frag_index = '0;
   logic [7:0]             req_frag_total = '0;
   logic [15:0]            req_byte_offset = '0;
   logic [15:0]            req_frame_length = '0;
   logic [7:0]             req_payload_length = '0;
   logic [7:0]             req_byte_position = '0;
   logic [7:0]             req_data_byte = '0;
   logic [8:0]             req_read_index = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_result_kind;
   logic [15:0]            rsp_done_frame_id;
   logic [10:0]            rsp_done_length;
   logic                   rsp_playable;
   logic signed [15:0]     rsp_sample_value;

   audio_fragment_reassembler dut (.*);

   always #6 clock = ~clock;

   // model of the block: registers, open frame and frame buffer
   bit          rx_on = 1'b1;
   logic [15:0] want_magic = '0;
   logic [7:0]  want_version = '0;
   logic [15:0] open_frame_id = NO_FRAME;
   logic [15:0] arrived_map = '0;
   logic [4:0]  open_frag_total = '0;
   logic [10:0] open_byte_total = '0;
   logic [7:0]  frame_bytes [AFR_BUFFER_BYTES];
   bit          byte_written [AFR_BUFFER_BYTES];
   bit          sample_ready [AFR_BUFFER_BYTES/2];
   int          ready_samples [$];

   rsp_item_type     pending_rsp [$];
   directed_row_type directed_rows [$];

   int errors = 0;
   int items_sent = 0;
   int items_taken = 0;
   int frames_done = 0;
   int samples_read = 0;
   int settings_run = 0;
   bit calm = 1'b0;

   // apply one item to the model; returns 1 when it yields a result item
   function automatic bit reassemble_item(input frag_item_type it, output rsp_item_type res,
                                          output bit took);
      int addr;
      int need;
      int s;
      res = '0;
      took = 1'b0;
      if (it.kind == KIND_READ) begin
         addr = int'(it.read_index) * 2;
         res.result_kind = RESULT_READ;
         if (addr + 1 < AFR_BUFFER_BYTES)
            res.sample_value = {frame_bytes[addr+1], frame_bytes[addr]};
         took = 1'b1;
         return 1'b1;
      end
      // header checks, any failure drops the byte silently
      if (!rx_on || it.magic != want_magic || it.version != want_version) return 1'b0;
      if (it.frame_length == 0 || it.frame_length > AFR_BUFFER_BYTES) return 1'b0;
      if (it.frag_total == 0 || it.frag_total > AFR_MAX_FRAGMENTS ||
          it.frag_index >= it.frag_total) return 1'b0;
      if (it.payload_length == 0 ||
          int'(it.byte_offset) + int'(it.payload_length) > int'(it.frame_length) ||
          it.byte_position >= it.payload_length) return 1'b0;
      // new frame when none is open or the id changes
      if (open_byte_total == 0 || it.frame_id != open_frame_id) begin
         open_frame_id = it.frame_id;
         arrived_map = '0;
         open_frag_total = 5'(it.frag_total);
         open_byte_total = 11'(it.frame_length);
      end else if (it.frame_length != open_byte_total || it.frag_total != open_frag_total) begin
         return 1'b0;
      end
      took = 1'b1;
      addr = int'(it.byte_offset) + int'(it.byte_position);
      if (addr < AFR_BUFFER_BYTES) begin
         frame_bytes[addr] = it.data_byte;
         byte_written[addr] = 1'b1;
         s = addr / 2;
         if (!sample_ready[s] && byte_written[2*s] && byte_written[2*s+1]) begin
            sample_ready[s] = 1'b1;
            ready_samples.push_back(s);
         end
      end
      if (int'(it.byte_position) + 1 != int'(it.payload_length)) return 1'b0;
      // last byte of the fragment marks its arrival
      arrived_map = arrived_map | 16'(1 << it.frag_index);
      need = ((1 << open_frag_total) - 1) & 16'hFFFF;
      if ((int'(arrived_map) & need) != need) return 1'b0;
      res.result_kind = RESULT_DONE;
      res.done_frame_id = open_frame_id;
      res.done_length = open_byte_total;
      res.playable = (open_byte_total >= 2) && !open_byte_total[0];
      open_frame_id = NO_FRAME;
      arrived_map = '0;
      open_frag_total = '0;
      open_byte_total = '0;
      return 1'b1;
   endfunction

   function automatic void compare_field(input string what, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
      end
   endfunction

   // fragment byte with the current header registers
   function automatic frag_item_type frag(input logic [15:0] fid, input logic [7:0] idx,
                                          input logic [7:0] total, input logic [15:0] off,
                                          input logic [15:0] flen, input logic [7:0] plen,
                                          input logic [7:0] pos, input logic [7:0] data);
      frag_item_type it;
      it = '0;
      it.kind = KIND_FRAGMENT;
      it.magic = want_magic;
      it.version = want_version;
      it.frame_id = fid;
      it.frag_index = idx;
      it.frag_total = total;
      it.byte_offset = off;
      it.frame_length = flen;
      it.payload_length = plen;
      it.byte_position = pos;
      it.data_byte = data;
      return it;
   endfunction

   function automatic frag_item_type sample_req(input logic [8:0] idx);
      frag_item_type it;
      it = '0;
      it.kind = KIND_READ;
      it.read_index = idx;
      return it;
   endfunction

   function automatic rsp_item_type done_rsp(input logic [15:0] fid, input logic [10:0] len,
                                             input logic play);
      rsp_item_type r;
      r = '0;
      r.result_kind = RESULT_DONE;
      r.done_frame_id = fid;
      r.done_length = len;
      r.playable = play;
      return r;
   endfunction

   function automatic rsp_item_type sample_rsp(input logic [15:0] value);
      rsp_item_type r;
      r = '0;
      r.result_kind = RESULT_READ;
      r.sample_value = value;
      return r;
   endfunction

   task automatic add_row(input frag_item_type it, input exp_src_type src,
                          input rsp_item_type want);
      directed_rows.push_back('{item: it, src: src, want: want});
   endtask

   // drive one item from a falling edge, wait for it to be taken
   task automatic push_item(input frag_item_type it, input exp_src_type src,
                            input rsp_item_type want);
      rsp_item_type guess;
      bit has;
      bit took;
      while (!calm && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_kind <= it.kind;
      req_magic <= it.magic;
      req_version <= it.version;
      req_frame_id <= it.frame_id;
      req_frag_index <= it.frag_index;
      req_frag_total <= it.frag_total;
      req_byte_offset <= it.byte_offset;
      req_frame_length <= it.frame_length;
      req_payload_length <= it.payload_length;
      req_byte_position <= it.byte_position;
      req_data_byte <= it.data_byte;
      req_read_index <= it.read_index;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      has = reassemble_item(it, guess, took);
      if (src == EXP_PREDICTED && has) pending_rsp.push_back(guess);
      else if (src == EXP_TYPED) pending_rsp.push_back(want);
      items_sent++;
      if (took) items_taken++;
      calm = (items_sent >= 400 && items_sent < 550);
      @(negedge clock);
   endtask

   // the caller drops csr_valid after its last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_RX_ENABLE: rx_on = value[0];
         CSR_EXPECTED_MAGIC: want_magic = value;
         CSR_EXPECTED_VERSION: want_version = value[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // unused upper data bits are random to check the masking
   task automatic apply_setting(input bit en, input logic [15:0] magic,
                                input logic [7:0] ver);
      write_reg(CSR_RX_ENABLE, {15'($urandom), en});
      write_reg(CSR_EXPECTED_MAGIC, magic);
      write_reg(CSR_EXPECTED_VERSION, {8'($urandom), ver});
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   // wait for every expected result, then cover the pipeline of dropped items
   task automatic settle_block();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         errors += pending_rsp.size();
         $display("%0t %0d expected result items never arrived", $time, pending_rsp.size());
         pending_rsp.delete();
      end
      @(negedge clock);
   endtask

   task automatic send_read();
      frag_item_type it;
      if (ready_samples.size() != 0) begin
         it = frag_item_type'({$urandom, $urandom, $urandom, $urandom});
         it.kind = KIND_READ;
         it.read_index = 9'(ready_samples[$urandom_range(0, ready_samples.size() - 1)]);
         push_item(it, EXP_PREDICTED, '0);
      end
   endtask

   // random header, sometimes with the right magic and version
   task automatic send_noise();
      frag_item_type it;
      it = frag_item_type'({$urandom, $urandom, $urandom, $urandom});
      it.kind = KIND_FRAGMENT;
      it.byte_position = 8'($urandom_range(0, 254));
      if ($urandom_range(0, 2) == 0) begin
         it.magic = want_magic;
         it.version = want_version;
      end
      push_item(it, EXP_PREDICTED, '0);
   endtask

   // one frame in shuffled fragment order; a damaged one loses or corrupts bytes
   task automatic send_frame(input bit damaged);
      int nfrag;
      int sum;
      int base;
      int slack;
      int r;
      int i;
      int j;
      int k;
      int tmp;
      int plen [16];
      int off [16];
      int order [16];
      logic [15:0] fid;
      bit backward;
      frag_item_type it;
      r = $urandom_range(0, 9);
      nfrag = (r < 6) ? $urandom_range(1, 4) : (r < 9) ? $urandom_range(5, 15) :
              AFR_MAX_FRAGMENTS;
      sum = 0;
      for (i = 0; i < nfrag; i++) begin
         plen[i] = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
         sum += plen[i];
         order[i] = i;
      end
      slack = $urandom_range(0, 3);
      base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, AFR_BUFFER_BYTES - sum - slack) : 0;
      off[0] = base;
      for (i = 1; i < nfrag; i++) off[i] = off[i-1] + plen[i-1];
      for (i = nfrag - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      fid = ($urandom_range(0, 15) == 0) ? NO_FRAME : 16'($urandom);
      for (i = 0; i < nfrag; i++) begin
         j = order[i];
         if (damaged && $urandom_range(0, 3) == 0) continue;
         backward = ($urandom_range(0, 4) == 0);
         for (k = 0; k < plen[j]; k++) begin
            it = frag(fid, 8'(j), 8'(nfrag), 16'(off[j]), 16'(base + sum + slack),
                      8'(plen[j]), 8'(backward ? plen[j] - 1 - k : k), 8'($urandom));
            if (damaged && $urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 4))
                  0: it.magic ^= 16'(1 << $urandom_range(0, 15));
                  1: it.version ^= 8'(1 << $urandom_range(0, 7));
                  2: it.frag_total += 1;
                  3: it.frame_length += 1;
                  default: it.byte_position = 8'(plen[j]);
               endcase
            end
            r = $urandom_range(0, 19);
            if (r == 0) send_read();
            else if (r == 1) send_noise();
            push_item(it, EXP_PREDICTED, '0);
         end
      end
   endtask

   // random traffic until enough items have reached the block's state
   task automatic run_traffic(input int quota);
      int start;
      int r;
      start = items_taken;
      while (items_taken - start < quota) begin
         r = $urandom_range(0, 99);
         if (r < 70) send_frame($urandom_range(0, 4) == 0);
         else if (r < 85) send_read();
         else send_noise();
      end
   endtask

   // result channel stall
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 37);
   end

   // result checking against the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_item_type w;
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t unexpected result item: kind %0d id 0x%0h length %0d sample 0x%0h",
                     $time, rsp_result_kind, rsp_done_frame_id, rsp_done_length,
                     rsp_sample_value);
         end else begin
            w = pending_rsp.pop_front();
            compare_field("result_kind", 16'(w.result_kind), 16'(rsp_result_kind));
            compare_field("done_frame_id", w.done_frame_id, rsp_done_frame_id);
            compare_field("done_length", 16'(w.done_length), 16'(rsp_done_length));
            compare_field("playable", 16'(w.playable), 16'(rsp_playable));
            compare_field("sample_value", w.sample_value, rsp_sample_value);
            if (w.result_kind == RESULT_DONE) frames_done++;
            else samples_read++;
         end
      end
   end

   initial begin : stimulus
      frag_item_type it;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single byte frame under the no-frame id, odd length
      add_row(frag(NO_FRAME, 0, 1, 0, 1, 1, 0, 8'hAB), EXP_TYPED, done_rsp(NO_FRAME, 1, 1'b0));
      // two fragment frame of four bytes, then its samples back
      add_row(frag(0, 0, 2, 0, 4, 2, 0, 8'h34), EXP_PREDICTED, '0);
      add_row(frag(0, 0, 2, 0, 4, 2, 1, 8'h12), EXP_PREDICTED, '0);
      add_row(frag(0, 1, 2, 2, 4, 2, 0, 8'hFF), EXP_PREDICTED, '0);
      add_row(frag(0, 1, 2, 2, 4, 2, 1, 8'h80), EXP_TYPED, done_rsp(0, 4, 1'b1));
      add_row(sample_req(0), EXP_TYPED, sample_rsp(16'h1234));
      add_row(sample_req(1), EXP_TYPED, sample_rsp(16'h80FF));
      // header drops: magic, version, lengths, counts, index, offset, position
      it = frag(9, 0, 1, 0, 2, 2, 1, 8'h55);
      it.magic = 16'hFFFF;
      add_row(it, EXP_DROPPED, '0);
      it = frag(9, 0, 1, 0, 2, 2, 1, 8'h55);
      it.version = 8'hFF;
      add_row(it, EXP_DROPPED, '0);
      add_row(frag(9, 0, 1, 0, 0, 2, 1, 8'h55), EXP_DROPPED, '0);
      add_row(frag(9, 0, 1, 0, 1025, 2, 1, 8'h55), EXP_DROPPED, '0);
      add_row(frag(9, 0, 0, 0, 2, 2, 1, 8'h55), EXP_DROPPED, '0);
      add_row(frag(9, 0, 17, 0, 2, 2, 1, 8'h55), EXP_DROPPED, '0);
      add_row(frag(9, 1, 1, 0, 2, 2, 1, 8'h55), EXP_DROPPED, '0);
      add_row(frag(9, 0, 1, 0, 2, 0, 0, 8'h55), EXP_DROPPED, '0);
      add_row(frag(9, 0, 1, 3, 4, 2, 1, 8'h55), EXP_DROPPED, '0);
      add_row(frag(9, 0, 1, 0, 2, 2, 2, 8'h55), EXP_DROPPED, '0);
      add_row(frag(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFE, 8'hFF),
              EXP_DROPPED, '0);
      // open frame, then count and length that disagree with it
      add_row(frag(5, 0, 2, 0, 3, 1, 0, 8'h11), EXP_PREDICTED, '0);
      add_row(frag(5, 1, 3, 1, 3, 2, 1, 8'h22), EXP_DROPPED, '0);
      add_row(frag(5, 1, 2, 1, 4, 2, 1, 8'h22), EXP_DROPPED, '0);
      // new id replaces the open frame and completes at once
      add_row(frag(6, 0, 1, 0, 2, 2, 1, 8'h33), EXP_TYPED, done_rsp(6, 2, 1'b1));
      // top of the buffer, last fragment of sixteen, largest payload
      add_row(frag(7, 15, 16, 1022, 1024, 2, 0, 8'h00), EXP_PREDICTED, '0);
      add_row(frag(7, 15, 16, 1022, 1024, 2, 1, 8'h7F), EXP_PREDICTED, '0);
      add_row(sample_req(511), EXP_TYPED, sample_rsp(16'h7F00));
      add_row(frag(7, 0, 16, 0, 1024, 255, 254, 8'hFF), EXP_PREDICTED, '0);

      foreach (directed_rows[i])
         push_item(directed_rows[i].item, directed_rows[i].src, directed_rows[i].want);
      settle_block();

      apply_setting(1'b1, 16'hFFFF, 8'hFF);
      run_traffic(260);
      settle_block();
      apply_setting(1'b0, 16'hFFFF, 8'hFF);
      run_traffic(3);
      settle_block();
      apply_setting(1'b1, 16'($urandom), 8'($urandom));
      run_traffic(260);
      settle_block();
      apply_setting(1'b1, 16'h0000, 8'h00);
      run_traffic(250);
      settle_block();

      $display("Sent %0d items, %0d of them taken by the reassembler, over %0d settings",
               items_sent, items_taken, settings_run + 1);
      $display("Checked %0d completed frames and %0d sample reads", frames_done, samples_read);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("%0t run timed out", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
